// File: rtl/jtqsl_pkg.sv
package jtqsl_pkg;
	localparam int JOINTS_DEF      = 12;
	localparam int QUEUE_DEPTH_DEF = 16;

	typedef enum logic [1:0] {
		CMD_MODE  = 2'd0,
		CMD_ENQ   = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_LIMIT = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_INIT    = 2'd0,
		MODE_EXECUTE = 2'd1,
		MODE_POLICY  = 2'd2,
		MODE_STOP    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_TRANS  = 2'd1,
		ST_WRONG_MODE = 2'd2,
		ST_FULL       = 2'd3
	} status_t;

	localparam logic [0:0] CFG_MAX_STEP  = 1'b0;
	localparam logic [0:0] CFG_THRESHOLD = 1'b1;

	// request handed from front to back through the queue
	typedef struct packed {
		cmd_t        cmd;
		mode_t       mode_req;
		logic [3:0]  joint;
		logic [15:0] value;
		logic [15:0] value_high;
		logic        last_joint;
	} req_t;
endpackage

// File: rtl/jtqsl_front.sv
module jtqsl_front
	import jtqsl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  req_t        in_req,
	output logic        q_valid,
	input  logic        q_pop,
	output req_t        q_req
);
	localparam int QD = 2;

	req_t       buf_q [QD];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_stall = (cnt_q == 2'(QD));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_req    = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end
endmodule

// File: rtl/jtqsl_back.sv
module jtqsl_back
	import jtqsl_pkg::*;
#(
	parameter int JOINTS      = JOINTS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_pop,
	input  req_t        q_req,
	input  logic [14:0] max_step,
	input  logic [14:0] arrive_tol,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [1:0]  status,
	output logic [3:0]  joint_out,
	output logic signed [15:0] position,
	output logic        last
);
	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
	localparam int AW = QW + JW;
	localparam int MD = QUEUE_DEPTH * JOINTS;

	typedef enum logic [2:0] {S_IDLE, S_PUSH, S_POPRD, S_POPWR, S_TICK, S_OUT} st_t;

	st_t st_q;
	mode_t mode_q;
	logic [QW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic active_q, reached_q;
	logic [JW-1:0] j_q;
	logic [AW-1:0] addr_q;
	logic signed [15:0] asm_q [JOINTS];
	logic signed [15:0] act_q [JOINTS];
	logic signed [15:0] cmdp_q [JOINTS];
	logic signed [15:0] lo_q [JOINTS];
	logic signed [15:0] hi_q [JOINTS];
	logic signed [15:0] mem [MD];
	logic signed [15:0] rd_q;

	logic jvalid, trans_ok, mode_run;
	logic signed [15:0] v, clamped;
	logic signed [17:0] diff, mag, stp, nd;
	logic [QW-1:0] tail;
	int tail_sum;

	assign jvalid   = (32'(q_req.joint) < JOINTS);
	assign mode_run = (mode_q == MODE_EXECUTE) || (mode_q == MODE_POLICY);
	always_comb begin
		trans_ok = (q_req.mode_req == mode_q)
			|| (mode_q == MODE_INIT && (q_req.mode_req == MODE_EXECUTE
				|| q_req.mode_req == MODE_POLICY))
			|| (mode_run && q_req.mode_req == MODE_STOP)
			|| (mode_q == MODE_STOP && q_req.mode_req == MODE_INIT);
		v = q_req.value;
		clamped = v;
		if (jvalid) begin
			if (v < lo_q[q_req.joint[JW-1:0]]) clamped = lo_q[q_req.joint[JW-1:0]];
			else if (v > hi_q[q_req.joint[JW-1:0]]) clamped = hi_q[q_req.joint[JW-1:0]];
		end
		diff = 18'(act_q[j_q]) - 18'(cmdp_q[j_q]);
		mag  = diff[17] ? -diff : diff;
		stp  = {3'b000, max_step};
		nd   = diff;
		if (diff > stp) nd = stp;
		else if (diff < -stp) nd = -stp;
		// tail slot of the target queue, wrapped by one compare
		tail_sum = 32'(head_q) + 32'(count_q);
		tail = QW'((tail_sum >= QUEUE_DEPTH) ? tail_sum - QUEUE_DEPTH : tail_sum);
	end

	assign q_pop = (st_q == S_IDLE) && q_valid && !(out_valid && out_stall);

	// queue memory: one joint written in each S_PUSH state; reads are registered into rd_q
	always_ff @(posedge clk) begin
		if (st_q == S_PUSH) mem[addr_q] <= asm_q[j_q];
		rd_q <= mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_req.cmd == CMD_ENQ && jvalid)
			asm_q[q_req.joint[JW-1:0]] <= clamped;
		if (st_q == S_POPWR) act_q[j_q] <= rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; mode_q <= MODE_INIT; head_q <= '0; count_q <= '0;
			active_q <= 1'b0; reached_q <= 1'b0;
			j_q <= '0; addr_q <= '0;
			out_valid <= 1'b0; kind <= 1'b0; status <= ST_OK;
			joint_out <= '0; position <= '0; last <= 1'b0;
			for (int i = 0; i < JOINTS; i++) begin
				cmdp_q[i] <= '0; lo_q[i] <= 16'sh8000; hi_q[i] <= 16'sh7fff;
			end
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (st_q)
				S_IDLE: if (q_pop) begin
					kind <= 1'b0; joint_out <= '0; position <= '0; last <= 1'b1;
					status <= ST_OK;
					case (q_req.cmd)
						CMD_MODE: begin
							out_valid <= 1'b1;
							if (trans_ok) mode_q <= q_req.mode_req;
							else status <= ST_BAD_TRANS;
						end
						CMD_ENQ: begin
							if (!q_req.last_joint) out_valid <= 1'b1;
							else if (!mode_run) begin
								out_valid <= 1'b1; status <= ST_WRONG_MODE;
							end else if (32'(count_q) >= QUEUE_DEPTH) begin
								out_valid <= 1'b1; status <= ST_FULL;
							end else begin
								j_q <= '0;
								st_q <= S_PUSH;
							end
						end
						CMD_LIMIT: begin
							out_valid <= 1'b1;
							if (jvalid) begin
								lo_q[q_req.joint[JW-1:0]] <= q_req.value;
								hi_q[q_req.joint[JW-1:0]] <= q_req.value_high;
							end
						end
						default: begin
							j_q <= '0; reached_q <= 1'b1;
							if (active_q) st_q <= S_TICK;
							else if (count_q != '0) begin
								addr_q <= AW'(32'(head_q) * JOINTS);
								st_q <= S_POPRD;
							end else out_valid <= 1'b1;
						end
					endcase
					if (q_req.cmd == CMD_ENQ)
						addr_q <= AW'(32'(tail) * JOINTS);
				end
				S_PUSH: begin
					if (32'(j_q) == JOINTS - 1) begin
						count_q <= count_q + 1'b1; out_valid <= 1'b1; st_q <= S_IDLE;
					end else begin
						j_q <= j_q + 1'b1; addr_q <= addr_q + 1'b1;
					end
				end
				S_POPRD: st_q <= S_POPWR;
				S_POPWR: begin
					if (32'(j_q) == JOINTS - 1) begin
						if (32'(head_q) == QUEUE_DEPTH - 1) head_q <= '0;
						else head_q <= head_q + 1'b1;
						count_q <= count_q - 1'b1; active_q <= 1'b1;
						j_q <= '0; st_q <= S_TICK;
					end else begin
						j_q <= j_q + 1'b1; addr_q <= addr_q + 1'b1; st_q <= S_POPRD;
					end
				end
				S_TICK: if (!out_valid || !out_stall) begin
					kind <= 1'b1; status <= ST_OK; joint_out <= 4'(j_q);
					out_valid <= 1'b1;
					last <= (32'(j_q) == JOINTS - 1);
					if (mag > {3'b000, arrive_tol}) begin
						reached_q <= 1'b0;
						cmdp_q[j_q] <= cmdp_q[j_q] + 16'(nd);
						position <= cmdp_q[j_q] + 16'(nd);
					end else position <= cmdp_q[j_q];
					if (32'(j_q) == JOINTS - 1) begin
						st_q <= S_OUT;
						if (reached_q && !(mag > {3'b000, arrive_tol}))
							active_q <= 1'b0;
					end else j_q <= j_q + 1'b1;
				end
				S_OUT: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/joint_target_queue_slew_limiter_unit.sv
// channel   direction  handshake        payload
// in        to block   valid / stall    command mode_request joint value value_high last_joint
// out       from block valid / stall    kind status joint_out position last
// cfg       to block   valid / ready    index data (max_step, arrive tolerance)
// mode, limit and non-final enqueue requests finish in S_IDLE; a push copies one joint a cycle
// through the single-port queue memory; a tick pops the head entry via S_POPRD/S_POPWR
// when needed, then walks one joint per cycle unless out_stall holds it, one result each, then S_OUT
// reset clears mode, queue pointers and commands, and sets the limit table to full range, at once
// a two-entry front queue takes requests while the back end waits on out_stall
module joint_target_queue_slew_limiter_unit
	import jtqsl_pkg::*;
#(
	parameter int JOINTS      = JOINTS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [1:0]  mode_request,
	input  logic [3:0]  joint,
	input  logic signed [15:0] value,
	input  logic signed [15:0] value_high,
	input  logic        last_joint,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [1:0]  status,
	output logic [3:0]  joint_out,
	output logic signed [15:0] position,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [14:0] cfg_data
);
	req_t        in_req, q_req;
	logic        q_valid, q_pop;
	logic [14:0] max_step_q, thr_q;

	// request as packed for the front queue
	assign in_req = '{cmd: cmd_t'(command), mode_req: mode_t'(mode_request), joint: joint,
		value: value, value_high: value_high, last_joint: last_joint};

	// register writes are always taken
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_step_q <= 15'd41;
			thr_q      <= 15'd4;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MAX_STEP:  max_step_q <= cfg_data;
				CFG_THRESHOLD: thr_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	jtqsl_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_req,
		.q_valid, .q_pop, .q_req
	);

	jtqsl_back #(.JOINTS(JOINTS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_req,
		.max_step(max_step_q), .arrive_tol(thr_q),
		.out_valid, .out_stall, .kind, .status, .joint_out, .position, .last
	);
endmodule
